@@ sv/tscal_pkg.sv @@
// Shared types, register codes and reset values for the touch calibration unit.
package tscal_pkg;

  localparam int unsigned PIX_W      = 12;
  localparam int unsigned REPLY_W    = 16;
  localparam int unsigned PROD_W     = 2 * PIX_W;
  localparam int unsigned DIV_BITS   = 3;

  // point status codes
  localparam logic [1:0] ST_VALID       = 2'd0;
  localparam logic [1:0] ST_NOT_PRESSED = 2'd1;
  localparam logic [1:0] ST_PEN_LIFTED  = 2'd2;

  typedef enum logic [2:0] {
    REG_USE_PEN_IRQ     = 3'd0,
    REG_TOUCH_THRESHOLD = 3'd1,
    REG_X_RAW_MIN       = 3'd2,
    REG_X_RAW_MAX       = 3'd3,
    REG_Y_RAW_MIN       = 3'd4,
    REG_Y_RAW_MAX       = 3'd5,
    REG_X_LAST_PIXEL    = 3'd6,
    REG_Y_LAST_PIXEL    = 3'd7
  } cfg_reg_e;

  localparam logic             RST_USE_PEN_IRQ  = 1'b1;
  localparam logic [PIX_W-1:0] RST_THRESHOLD    = 12'd200;
  localparam logic [PIX_W-1:0] RST_X_RAW_MIN    = 12'd200;
  localparam logic [PIX_W-1:0] RST_X_RAW_MAX    = 12'd3900;
  localparam logic [PIX_W-1:0] RST_Y_RAW_MIN    = 12'd300;
  localparam logic [PIX_W-1:0] RST_Y_RAW_MAX    = 12'd3800;
  localparam logic [PIX_W-1:0] RST_X_LAST_PIXEL = 12'd319;
  localparam logic [PIX_W-1:0] RST_Y_LAST_PIXEL = 12'd239;

  typedef struct packed {
    logic               pen_irq_level;
    logic [REPLY_W-1:0] probe_reply;
    logic [REPLY_W-1:0] x_reply_0;
    logic [REPLY_W-1:0] x_reply_1;
    logic [REPLY_W-1:0] x_reply_2;
    logic [REPLY_W-1:0] x_reply_3;
    logic [REPLY_W-1:0] y_reply_0;
    logic [REPLY_W-1:0] y_reply_1;
    logic [REPLY_W-1:0] y_reply_2;
    logic [REPLY_W-1:0] y_reply_3;
  } sample_t;

  typedef struct packed {
    logic [1:0]       point_status;
    logic [PIX_W-1:0] x_pixel;
    logic [PIX_W-1:0] y_pixel;
  } point_t;

  typedef struct packed {
    logic [2:0]       index;
    logic [PIX_W-1:0] value;
  } cfg_wr_t;

  // outcome known before the divide: status and clamp overrides
  typedef struct packed {
    logic [1:0]       status;
    logic             x_force;
    logic [PIX_W-1:0] x_fval;
    logic             y_force;
    logic [PIX_W-1:0] y_fval;
  } side_t;

  typedef struct packed {
    logic [PROD_W-1:0] num_x;
    logic [PIX_W-1:0]  den_x;
    logic [PROD_W-1:0] num_y;
    logic [PIX_W-1:0]  den_y;
    side_t             side;
  } div_req_t;

endpackage

@@ sv/tscal_stream_if.sv @@
// Valid/ready channel carrying one payload struct.
interface tscal_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ sv/tscal_div.sv @@
// Pipelined restoring divider for both axes, DivBits quotient bits per stage.
module tscal_div #(
  parameter int unsigned DivBits = tscal_pkg::DIV_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tscal_pkg::div_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tscal_pkg::point_t   out_data
);

  localparam int unsigned QuoW   = tscal_pkg::PIX_W;
  localparam int unsigned Stages = (QuoW + DivBits - 1) / DivBits;

  typedef struct packed {
    logic [QuoW-1:0]  rem_x;
    logic [QuoW-1:0]  work_x;
    logic [QuoW-1:0]  den_x;
    logic [QuoW-1:0]  rem_y;
    logic [QuoW-1:0]  work_y;
    logic [QuoW-1:0]  den_y;
    tscal_pkg::side_t side;
  } stage_t;

  // one long-division step: work shifts out dividend bits, shifts in quotient bits
  function automatic logic [2*QuoW-1:0] div_step(logic [QuoW-1:0] rem,
                                                 logic [QuoW-1:0] work,
                                                 logic [QuoW-1:0] den);
    logic [QuoW:0]   trial;
    logic            qbit;
    logic [QuoW-1:0] rem_n;
    trial = {rem, work[QuoW-1]};
    qbit  = (trial >= {1'b0, den});
    rem_n = qbit ? QuoW'(trial - {1'b0, den}) : trial[QuoW-1:0];
    return {rem_n, work[QuoW-2:0], qbit};
  endfunction

  stage_t st   [Stages];
  stage_t nxt  [Stages];
  logic   vld  [Stages];
  logic   rdy  [Stages];
  stage_t init;

  // quotient is below 2^QuoW, so the upper half starts as the remainder
  always_comb begin
    init.rem_x  = in_data.num_x[tscal_pkg::PROD_W-1:QuoW];
    init.work_x = in_data.num_x[QuoW-1:0];
    init.den_x  = in_data.den_x;
    init.rem_y  = in_data.num_y[tscal_pkg::PROD_W-1:QuoW];
    init.work_y = in_data.num_y[QuoW-1:0];
    init.den_y  = in_data.den_y;
    init.side   = in_data.side;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    stage_t src;
    logic   vin;
    logic   rdy_down;

    if (s == 0) begin : g_first
      assign src = init;
      assign vin = in_valid;
    end else begin : g_rest
      assign src = st[s-1];
      assign vin = vld[s-1];
    end

    if (s == Stages - 1) begin : g_last
      assign rdy_down = out_ready;
    end else begin : g_mid
      assign rdy_down = rdy[s+1];
    end

    assign rdy[s] = !vld[s] || rdy_down;

    always_comb begin
      nxt[s] = src;
      for (int k = 0; k < DivBits; k++) begin
        if (s * DivBits + k < QuoW) begin
          {nxt[s].rem_x, nxt[s].work_x} = div_step(nxt[s].rem_x, nxt[s].work_x, nxt[s].den_x);
          {nxt[s].rem_y, nxt[s].work_y} = div_step(nxt[s].rem_y, nxt[s].work_y, nxt[s].den_y);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vin) begin
        st[s] <= nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[Stages-1];

  always_comb begin
    out_data.point_status = st[Stages-1].side.status;
    out_data.x_pixel = st[Stages-1].side.x_force ? st[Stages-1].side.x_fval
                                                 : st[Stages-1].work_x;
    out_data.y_pixel = st[Stages-1].side.y_force ? st[Stages-1].side.y_fval
                                                 : st[Stages-1].work_y;
  end

endmodule

@@ sv/touch_sample_to_screen_point_unit.sv @@
// Touch sample to screen point: averaging, pen checks and clamped linear mapping.
// Pipeline: pen decision and averages, then status, clamps and offsets, then products, then the divider.
// Throughput: one request per cycle while the output is ready; the divider is a pipeline of DivBits-bit stages.
// Each stage holds its item while the next one cannot accept it, so bubbles close up under stall.
// Reset (synchronous, rst high) empties the pipeline and loads the default calibration.
module touch_sample_to_screen_point_unit #(
  parameter int unsigned DivBits = tscal_pkg::DIV_BITS
) (
  input  logic           clk,
  input  logic           rst,
  tscal_stream_if.sink   sample,
  tscal_stream_if.source point,
  tscal_stream_if.sink   cfg
);

  localparam int unsigned PW = tscal_pkg::PIX_W;

  // configuration registers
  logic          use_pen_irq;
  logic [PW-1:0] touch_threshold;
  logic [PW-1:0] x_raw_min;
  logic [PW-1:0] x_raw_max;
  logic [PW-1:0] y_raw_min;
  logic [PW-1:0] y_raw_max;
  logic [PW-1:0] x_last_pixel;
  logic [PW-1:0] y_last_pixel;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_pen_irq     <= tscal_pkg::RST_USE_PEN_IRQ;
      touch_threshold <= tscal_pkg::RST_THRESHOLD;
      x_raw_min       <= tscal_pkg::RST_X_RAW_MIN;
      x_raw_max       <= tscal_pkg::RST_X_RAW_MAX;
      y_raw_min       <= tscal_pkg::RST_Y_RAW_MIN;
      y_raw_max       <= tscal_pkg::RST_Y_RAW_MAX;
      x_last_pixel    <= tscal_pkg::RST_X_LAST_PIXEL;
      y_last_pixel    <= tscal_pkg::RST_Y_LAST_PIXEL;
    end else if (cfg.valid) begin
      unique case (tscal_pkg::cfg_reg_e'(cfg.data.index))
        tscal_pkg::REG_USE_PEN_IRQ:     use_pen_irq     <= cfg.data.value[0];
        tscal_pkg::REG_TOUCH_THRESHOLD: touch_threshold <= cfg.data.value;
        tscal_pkg::REG_X_RAW_MIN:       x_raw_min       <= cfg.data.value;
        tscal_pkg::REG_X_RAW_MAX:       x_raw_max       <= cfg.data.value;
        tscal_pkg::REG_Y_RAW_MIN:       y_raw_min       <= cfg.data.value;
        tscal_pkg::REG_Y_RAW_MAX:       y_raw_max       <= cfg.data.value;
        tscal_pkg::REG_X_LAST_PIXEL:    x_last_pixel    <= cfg.data.value;
        tscal_pkg::REG_Y_LAST_PIXEL:    y_last_pixel    <= cfg.data.value;
        default: ;
      endcase
    end
  end

  function automatic logic [PW-1:0] sample_of(logic [tscal_pkg::REPLY_W-1:0] reply);
    return reply[PW+2:3];
  endfunction

  function automatic logic [PW-1:0] avg4(logic [PW-1:0] a, logic [PW-1:0] b,
                                         logic [PW-1:0] c, logic [PW-1:0] d);
    logic [PW+1:0] sum;
    sum = (PW+2)'(a) + (PW+2)'(b) + (PW+2)'(c) + (PW+2)'(d);
    return sum[PW+1:2];
  endfunction

  // stage 1: pen decision and axis averages
  logic          vld1;
  logic          rdy1;
  logic          pressed1;
  logic [PW-1:0] ax1;
  logic [PW-1:0] ay1;

  // stage 2: status, clamps, offsets
  logic             vld2;
  logic             rdy2;
  logic [PW-1:0]    diff_x2;
  logic [PW-1:0]    den_x2;
  logic [PW-1:0]    diff_y2;
  logic [PW-1:0]    den_y2;
  tscal_pkg::side_t side2;
  tscal_pkg::side_t side_next;

  // stage 3: products
  logic                div_ready;
  logic                vld3;
  logic                rdy3;
  tscal_pkg::div_req_t req3;

  assign rdy1 = !vld1 || rdy2;
  assign rdy2 = !vld2 || rdy3;
  assign rdy3 = !vld3 || div_ready;
  assign sample.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= sample.valid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && sample.valid) begin
      pressed1 <= use_pen_irq ? !sample.data.pen_irq_level
                              : (sample_of(sample.data.probe_reply) > touch_threshold);
      ax1 <= avg4(sample_of(sample.data.x_reply_0), sample_of(sample.data.x_reply_1),
                  sample_of(sample.data.x_reply_2), sample_of(sample.data.x_reply_3));
      ay1 <= avg4(sample_of(sample.data.y_reply_0), sample_of(sample.data.y_reply_1),
                  sample_of(sample.data.y_reply_2), sample_of(sample.data.y_reply_3));
    end
  end

  // low clamp wins over high clamp; any non-valid status forces zeros
  always_comb begin
    side_next.status = tscal_pkg::ST_VALID;
    if (!pressed1) begin
      side_next.status = tscal_pkg::ST_NOT_PRESSED;
    end else if (ax1 < touch_threshold || ay1 < touch_threshold) begin
      side_next.status = tscal_pkg::ST_PEN_LIFTED;
    end
    side_next.x_force = 1'b1;
    side_next.x_fval  = '0;
    side_next.y_force = 1'b1;
    side_next.y_fval  = '0;
    if (side_next.status == tscal_pkg::ST_VALID) begin
      if (ax1 <= x_raw_min) begin
        side_next.x_fval = '0;
      end else if (ax1 >= x_raw_max) begin
        side_next.x_fval = x_last_pixel;
      end else begin
        side_next.x_force = 1'b0;
      end
      if (ay1 <= y_raw_min) begin
        side_next.y_fval = '0;
      end else if (ay1 >= y_raw_max) begin
        side_next.y_fval = y_last_pixel;
      end else begin
        side_next.y_force = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && vld1) begin
      side2   <= side_next;
      diff_x2 <= ax1 - x_raw_min;
      den_x2  <= x_raw_max - x_raw_min;
      diff_y2 <= ay1 - y_raw_min;
      den_y2  <= y_raw_max - y_raw_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && vld2) begin
      req3.num_x <= tscal_pkg::PROD_W'(diff_x2) * tscal_pkg::PROD_W'(x_last_pixel);
      req3.num_y <= tscal_pkg::PROD_W'(diff_y2) * tscal_pkg::PROD_W'(y_last_pixel);
      req3.den_x <= den_x2;
      req3.den_y <= den_y2;
      req3.side  <= side2;
    end
  end

  tscal_div #(
    .DivBits(DivBits)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld3),
    .in_ready (div_ready),
    .in_data  (req3),
    .out_valid(point.valid),
    .out_ready(point.ready),
    .out_data (point.data)
  );

endmodule

@@ sv/tscal_chk.sv @@
// Port-level checks on the touch calibration unit, bound to the top level.
module tscal_chk (
  input logic              clk,
  input logic              rst,
  input logic              sample_ready,
  input logic              point_valid,
  input logic              point_ready,
  input tscal_pkg::point_t point_data,
  input logic              cfg_ready
);

  // a waiting result must not change or vanish
  a_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_ready |=> point_valid && $stable(point_data))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point_data.point_status == tscal_pkg::ST_VALID ||
                     point_data.point_status == tscal_pkg::ST_NOT_PRESSED ||
                     point_data.point_status == tscal_pkg::ST_PEN_LIFTED))
    else $error("undefined point status");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_data.point_status != tscal_pkg::ST_VALID
      |-> point_data.x_pixel == '0 && point_data.y_pixel == '0)
    else $error("rejected point carries coordinates");

  a_empty: assert property (@(posedge clk)
    rst |=> !point_valid && sample_ready && cfg_ready)
    else $error("pipeline not empty after reset");

endmodule

bind touch_sample_to_screen_point_unit tscal_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .sample_ready(sample.ready),
  .point_valid (point.valid),
  .point_ready (point.ready),
  .point_data  (point.data),
  .cfg_ready   (cfg.ready)
);
